@@ design/mf2d_pkg.sv @@
// Shared types and constants for the 2-D median filter.
// Holds pixel and register widths, register indexes and the queue status type.
// No dependencies.
package mf2d_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_RADIUS_W = 2;
	localparam int OUT_ROW_W  = 12;
	localparam int MAX_HEIGHT = 4096;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	// Input item kinds.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Status of a small queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Configuration as seen by the front end.
	typedef struct packed {
		logic [CFG_WIDTH_W-1:0]  width;
		logic [CFG_HEIGHT_W-1:0] height;
		logic [CFG_RADIUS_W-1:0] radius;
		logic                    restart;
	} cfg_t;

endpackage

@@ design/median_filter_2d_core.sv @@
// Streaming 2-D median filter over a square, zero-padded window of side 2r+1 (r up to 3).
// Pixels enter in raster order through a push/full port and results leave through
// empty/pop; results trail the input by r rows and r columns, and after the last pixel
// the source sends r*width+r drain items. The block takes one item per clock while the
// window queue is not full: the line store does one read and one write per cycle, and the
// selector is an eight-stage pipeline deciding one bit of the median per stage. Registers
// sit at byte addresses 0 (width), 4 (height) and 8 (radius); a write to any of them
// restarts the frame.
// Depends on mf2d_pkg, mf2d_front, mf2d_sel and mf2d_fifo.
module median_filter_2d_core import mf2d_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  push,
	output logic                  full,
	input  logic                  kind,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  empty,
	input  logic                  pop,
	output logic [PIX_W-1:0]      median,
	output logic                  frame_end
);

	localparam int SIDE  = 2 * MAX_RADIUS + 1;
	localparam int N     = SIDE * SIDE;
	localparam int K_W   = $clog2(N);
	localparam int ENT_W = N * PIX_W + N + K_W + 1;

	// Configuration registers.
	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;
	logic [CFG_RADIUS_W-1:0] radius_q;
	logic                    wr_en;
	logic [1:0]              reg_idx;
	cfg_t                    cfg;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_WIDTH_W'(640);
			height_q <= CFG_HEIGHT_W'(480);
			radius_q <= CFG_RADIUS_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_WIDTH_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_HEIGHT_W-1:0];
				REG_RADIUS: radius_q <= pwdata[CFG_RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read.
	always_comb begin
		case (reg_idx)
			REG_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_HEIGHT: prdata = APB_DATA_W'(height_q);
			REG_RADIUS: prdata = APB_DATA_W'(radius_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.width   = width_q;
	assign cfg.height  = height_q;
	assign cfg.radius  = radius_q;
	assign cfg.restart = wr_en && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT
			|| reg_idx == REG_RADIUS);

	// Front end to window queue.
	logic             mq_push, mq_pop;
	logic [ENT_W-1:0] mq_din, mq_dout;
	q_status_t        mq_st;

	mf2d_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.push   (push),
		.full   (full),
		.kind   (kind),
		.pixel  (pixel),
		.q_push (mq_push),
		.q_data (mq_din),
		.q_full (mq_st.full)
	);

	mf2d_fifo #(
		.W     (ENT_W),
		.DEPTH (2)
	) u_win_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.pop    (mq_pop),
		.din    (mq_din),
		.dout   (mq_dout),
		.status (mq_st)
	);

	// Median selection and result queue.
	logic             oq_push;
	logic [PIX_W-1:0] sel_median;
	logic             sel_fe;
	q_status_t        oq_st;

	mf2d_sel #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_st      (mq_st),
		.q_pop     (mq_pop),
		.q_data    (mq_dout),
		.oq_st     (oq_st),
		.oq_push   (oq_push),
		.median    (sel_median),
		.frame_end (sel_fe)
	);

	mf2d_fifo #(
		.W     (PIX_W + 1),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.pop    (pop),
		.din    ({sel_median, sel_fe}),
		.dout   ({median, frame_end}),
		.status (oq_st)
	);

	assign empty = oq_st.empty;

	// No window is offered to a full queue.
	a_win_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mq_push && mq_st.full))
		else $error("window pushed into full queue");

	// The selector never hands a result to a full result queue.
	a_res_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(oq_push && oq_st.full))
		else $error("result pushed into full queue");

	// The selector only pulls a window that is there.
	a_win_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mq_pop && mq_st.empty))
		else $error("window popped from empty queue");

endmodule

@@ design/mf2d_fifo.sv @@
// Small first-in first-out queue built from flip-flops.
// Used between the front end and the selector, and on the result side.
// Depends on mf2d_pkg for the status type.
module mf2d_fifo import mf2d_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         pop,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout,
	output q_status_t    status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign dout    = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ design/mf2d_front.sv @@
// Front end of the median filter: position counters, line store and window registers.
// Builds the zero-padded window of each output pixel and hands it to the selector queue.
// Depends on mf2d_pkg.
module mf2d_front import mf2d_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3,
	localparam int SIDE  = 2 * MAX_RADIUS + 1,
	localparam int N     = SIDE * SIDE,
	localparam int K_W   = $clog2(N),
	localparam int ENT_W = N * PIX_W + N + K_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             push,
	output logic             full,
	input  logic             kind,
	input  logic [PIX_W-1:0] pixel,
	output logic             q_push,
	output logic [ENT_W-1:0] q_data,
	input  logic             q_full
);

	localparam int STACK = 2 * MAX_RADIUS;
	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW_W  = $clog2(MAX_WIDTH + 1);
	localparam int THR_W = EW_W + 2;

	// Effective configuration.
	logic [EW_W-1:0]         ew;
	logic [CFG_HEIGHT_W-1:0] eh;
	logic [CFG_RADIUS_W-1:0] er;
	logic [THR_W-1:0]        thr;

	always_comb begin
		if (cfg.width == '0) begin
			ew = EW_W'(1);
		end else if (32'(cfg.width) > MAX_WIDTH) begin
			ew = EW_W'(MAX_WIDTH);
		end else begin
			ew = EW_W'(cfg.width);
		end
		if (cfg.height == '0) begin
			eh = CFG_HEIGHT_W'(1);
		end else if (32'(cfg.height) > MAX_HEIGHT) begin
			eh = CFG_HEIGHT_W'(MAX_HEIGHT);
		end else begin
			eh = cfg.height;
		end
		if (32'(cfg.radius) > MAX_RADIUS) begin
			er = CFG_RADIUS_W'(MAX_RADIUS);
		end else begin
			er = cfg.radius;
		end
		// Number of items before the first result: radius rows plus radius columns.
		thr = (er[0] ? THR_W'(ew) : '0) + (er[1] ? THR_W'({ew, 1'b0}) : '0) + THR_W'(er);
	end

	// Position counters.
	logic [COL_W-1:0]     in_col_q, out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic [THR_W-1:0]     lead_q;
	logic                 acc, emit0, fe0, in_wrap, out_wrap;

	// First stage registers.
	logic                  v_s1, emit_s1, fe_s1, fwd_s1;
	logic [COL_W-1:0]      col_s1;
	logic [PIX_W-1:0]      px_s1;
	logic [CFG_RADIUS_W-1:0] r_s1;
	logic [SIDE-1:0]       row_ok_s1, col_ok_s1;
	logic [STACK*PIX_W-1:0] rd_s1, last_wr_q;
	logic                  advance;

	logic [SIDE-1:0] row_ok0, col_ok0;

	assign advance = v_s1 && (!emit_s1 || !q_full);
	assign full    = v_s1 && !advance;
	assign acc     = push && !full;
	assign q_push  = v_s1 && emit_s1 && !q_full;

	assign emit0    = (lead_q == thr);
	assign fe0      = emit0 && (CFG_HEIGHT_W'(out_row_q) == eh - CFG_HEIGHT_W'(1))
			&& (EW_W'(out_col_q) == ew - EW_W'(1));
	assign in_wrap  = (EW_W'(in_col_q) + EW_W'(1) >= ew);
	assign out_wrap = (EW_W'(out_col_q) + EW_W'(1) >= ew);

	// Window rows and columns that lie inside the image.
	always_comb begin
		int rr, cc, si;
		si = 2 * int'(er) + 1;
		for (int d = 0; d < SIDE; d++) begin
			rr = int'(out_row_q) - int'(er) + d;
			cc = int'(out_col_q) - int'(er) + d;
			row_ok0[d] = (d < si) && (rr >= 0) && (rr < int'(eh));
			col_ok0[d] = (d < si) && (cc >= 0) && (cc < int'(ew));
		end
	end

	// Counters advance per accepted item; a register write or the frame end restarts them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q    <= '0;
		end else if (cfg.restart || (acc && fe0)) begin
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q    <= '0;
		end else if (acc) begin
			in_col_q <= in_wrap ? '0 : in_col_q + COL_W'(1);
			if (lead_q < thr) begin
				lead_q <= lead_q + THR_W'(1);
			end
			if (emit0) begin
				out_col_q <= out_wrap ? '0 : out_col_q + COL_W'(1);
				if (out_wrap) begin
					out_row_q <= out_row_q + OUT_ROW_W'(1);
				end
			end
		end
	end

	// First stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	// First stage payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1    <= in_col_q;
			px_s1     <= (kind == KIND_DRAIN) ? '0 : pixel;
			emit_s1   <= emit0;
			fe_s1     <= fe0;
			r_s1      <= er;
			row_ok_s1 <= row_ok0;
			col_ok_s1 <= col_ok0;
			fwd_s1    <= v_s1 && (col_s1 == in_col_q);
		end
	end

	// Line store: one word per column holding the previous rows, newest first.
	logic [STACK*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [STACK*PIX_W-1:0] word, new_word;

	always_ff @(posedge clk) begin
		if (advance) begin
			line_mem[col_s1] <= new_word;
			last_wr_q        <= new_word;
		end
		if (acc) begin
			rd_s1 <= line_mem[in_col_q];
		end
	end

	// A back-to-back item at the same column takes the word just written.
	assign word = fwd_s1 ? last_wr_q : rd_s1;

	// Column vector and line store shift.
	logic [PIX_W-1:0] vec [SIDE];

	always_comb begin
		vec[0] = px_s1;
		for (int j = 1; j < SIDE; j++) begin
			vec[j] = word[(j-1)*PIX_W +: PIX_W];
		end
		for (int i = 0; i < STACK; i++) begin
			if (i == 0) begin
				new_word[0 +: PIX_W] = (r_s1 != '0) ? px_s1 : word[0 +: PIX_W];
			end else if (i < 2 * int'(r_s1)) begin
				new_word[i*PIX_W +: PIX_W] = word[(i-1)*PIX_W +: PIX_W];
			end else begin
				new_word[i*PIX_W +: PIX_W] = word[i*PIX_W +: PIX_W];
			end
		end
	end

	// Window registers shift left and take the new column on the right.
	logic [PIX_W-1:0] win_q [SIDE][SIDE];
	logic [PIX_W-1:0] win_n [SIDE][SIDE];

	always_comb begin
		int si;
		si = 2 * int'(r_s1) + 1;
		for (int dy = 0; dy < SIDE; dy++) begin
			for (int dx = 0; dx < SIDE; dx++) begin
				win_n[dy][dx] = win_q[dy][dx];
				if (dy < si) begin
					if (dx + 1 < si) begin
						win_n[dy][dx] = win_q[dy][(dx + 1) % SIDE];
					end else if (dx == si - 1) begin
						for (int j = 0; j < SIDE; j++) begin
							if (j == si - 1 - dy) begin
								win_n[dy][dx] = vec[j];
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int dy = 0; dy < SIDE; dy++) begin
				for (int dx = 0; dx < SIDE; dx++) begin
					win_q[dy][dx] <= '0;
				end
			end
		end else if (advance) begin
			win_q <= win_n;
		end
	end

	// Queue entry: masked values, active slots, median rank and frame end.
	logic [N*PIX_W-1:0] vals;
	logic [N-1:0]       act;
	logic [K_W-1:0]     rank;

	always_comb begin
		int si;
		si = 2 * int'(r_s1) + 1;
		for (int dy = 0; dy < SIDE; dy++) begin
			for (int dx = 0; dx < SIDE; dx++) begin
				vals[(dy*SIDE+dx)*PIX_W +: PIX_W] =
					(row_ok_s1[dy] && col_ok_s1[dx]) ? win_n[dy][dx] : '0;
				act[dy*SIDE+dx] = (dy < si) && (dx < si);
			end
		end
		// Rank of the median is half the window size, 2r(r+1).
		rank = K_W'(2 * int'(r_s1) * (int'(r_s1) + 1));
	end

	assign q_data = {vals, act, rank, fe_s1};

endmodule

@@ design/mf2d_sel.sv @@
// Back end of the median filter: radix selection of the median, one bit per stage.
// Each stage counts active values with a zero in the current bit and narrows the set.
// Depends on mf2d_pkg.
module mf2d_sel import mf2d_pkg::*; #(
	parameter int MAX_RADIUS = 3,
	localparam int SIDE  = 2 * MAX_RADIUS + 1,
	localparam int N     = SIDE * SIDE,
	localparam int K_W   = $clog2(N),
	localparam int ENT_W = N * PIX_W + N + K_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  q_status_t        q_st,
	output logic             q_pop,
	input  logic [ENT_W-1:0] q_data,
	input  q_status_t        oq_st,
	output logic             oq_push,
	output logic [PIX_W-1:0] median,
	output logic             frame_end
);

	localparam int CNT_W = $clog2(N + 1);

	// Index 0 is the queue head; index i is the register of stage i.
	logic               v_s    [PIX_W+1];
	logic [N*PIX_W-1:0] vals_s [PIX_W+1];
	logic [N-1:0]       act_s  [PIX_W+1];
	logic [K_W-1:0]     k_s    [PIX_W+1];
	logic [PIX_W-1:0]   res_s  [PIX_W+1];
	logic               fe_s   [PIX_W+1];
	logic               en;

	// The whole pipeline holds while the last stage cannot leave.
	assign en      = !(v_s[PIX_W] && oq_st.full);
	assign q_pop   = en && !q_st.empty;
	assign oq_push = v_s[PIX_W] && en;

	assign v_s[0] = !q_st.empty;
	assign {vals_s[0], act_s[0], k_s[0], fe_s[0]} = q_data;
	assign res_s[0] = '0;

	for (genvar i = 0; i < PIX_W; i++) begin : g_stage
		localparam int B = PIX_W - 1 - i;
		logic [N-1:0]     zeros, ones;
		logic [CNT_W-1:0] cnt;
		logic [N-1:0]     act_n;
		logic [K_W-1:0]   k_n;
		logic [PIX_W-1:0] res_n;

		// Count active values with a zero in bit B and keep the side holding the rank.
		always_comb begin
			cnt = '0;
			for (int e = 0; e < N; e++) begin
				zeros[e] = act_s[i][e] && !vals_s[i][e*PIX_W + B];
				ones[e]  = act_s[i][e] && vals_s[i][e*PIX_W + B];
				cnt = cnt + CNT_W'(zeros[e]);
			end
			res_n = res_s[i];
			if (CNT_W'(k_s[i]) < cnt) begin
				act_n    = zeros;
				k_n      = k_s[i];
				res_n[B] = 1'b0;
			end else begin
				act_n    = ones;
				k_n      = K_W'(CNT_W'(k_s[i]) - cnt);
				res_n[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vals_s[i+1] <= vals_s[i];
				act_s[i+1]  <= act_n;
				k_s[i+1]    <= k_n;
				res_s[i+1]  <= res_n;
				fe_s[i+1]   <= fe_s[i];
			end
		end
	end

	assign median    = res_s[PIX_W];
	assign frame_end = fe_s[PIX_W];

endmodule
